// File: hw/rtl/tuner_pll_word_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Tuner PLL word generator assertion macros
// Shared concurrent assertion forms for the tuner PLL word generator.
// ----------------------------------------------------------------------------
`ifndef TUNER_PLL_WORD_GENERATOR_TOP_DEFINES_SVH
`define TUNER_PLL_WORD_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define TPWG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tpwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator package
// Widths, constants, register map and shared types.
// ----------------------------------------------------------------------------
package tpwg_pkg;

   localparam int FREQ_W      = 21;
   localparam int IF_W        = 16;
   localparam int WORD_W      = 16;
   localparam int WORDS_W     = 48;
   localparam int FMSET_W     = 58;
   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 58;
   localparam int CSR_INDEX_W = 3;

   localparam int SUM_W       = FREQ_W + 1;
   localparam int TV_SHIFT    = 4;
   localparam int DIVIDEND_W  = SUM_W + TV_SHIFT;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 36;
   localparam int PROD_W      = DIVIDEND_W + RECIP_W;
   localparam int DIVIDER_W   = PROD_W - RECIP_SHIFT;

   localparam int QUEUE_DEPTH = 4;

   // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for x below 2**26
   localparam logic [RECIP_W-1:0]   RECIP_1000     = 27'd68719477;
   localparam logic [FREQ_W-1:0]    FM_PRETUNE_KHZ = 21'd150000;
   localparam logic [IF_W-1:0]      FM_IF_KHZ      = 16'd10700;
   localparam logic [DIVIDER_W-1:0] DIV_MAX        = 17'd32767;
   localparam logic [4:0]           FM_SCALE       = 5'd20;

   localparam logic [IF_W-1:0]    RST_TV_IF_KHZ     = 16'd45750;
   localparam logic [FREQ_W-1:0]  RST_TV_MIN_KHZ    = 21'd55250;
   localparam logic [FREQ_W-1:0]  RST_TV_MAX_KHZ    = 21'd801250;
   localparam logic [FREQ_W-1:0]  RST_BAND_HIGH_KHZ = 21'd454000;
   localparam logic [FREQ_W-1:0]  RST_BAND_MID_KHZ  = 21'd160000;
   localparam logic [WORDS_W-1:0] RST_BAND_WORDS    = 48'h8E30_8E90_8EA0;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_FM_OFF = 2'd2,
      ST_OVF    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_TV  = 2'd0,
      OP_FM  = 2'd1,
      OP_ERR = 2'd2
   } op_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TV_IF_KHZ     = 3'd0,
      REG_TV_MIN_KHZ    = 3'd1,
      REG_TV_MAX_KHZ    = 3'd2,
      REG_BAND_HIGH_KHZ = 3'd3,
      REG_BAND_MID_KHZ  = 3'd4,
      REG_BAND_WORDS    = 3'd5,
      REG_FM_SETTINGS   = 3'd6,
      REG_PORT_BITS     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [IF_W-1:0]    tv_if_khz;
      logic [FREQ_W-1:0]  tv_min_khz;
      logic [FREQ_W-1:0]  tv_max_khz;
      logic [FREQ_W-1:0]  band_high_khz;
      logic [FREQ_W-1:0]  band_mid_khz;
      logic [WORDS_W-1:0] band_words;
      logic [FREQ_W-1:0]  fm_min_khz;
      logic [FREQ_W-1:0]  fm_max_khz;
      logic [WORD_W-1:0]  fm_word;
      logic [BYTE_W-1:0]  port_bits;
   } cfg_type;

   typedef struct packed {
      op_kind_type           kind;
      status_type            status;
      logic                  last;
      logic                  chain;
      logic [FREQ_W-1:0]     freq;
      logic [DIVIDEND_W-1:0] dividend;
   } op_type;

endpackage

// File: hw/rtl/tpwg_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning request channel
// Valid/ready channel carrying a frequency and a TV/FM mode.
// ----------------------------------------------------------------------------
interface tpwg_req_if;
   logic                        valid;
   logic                        ready;
   logic [tpwg_pkg::FREQ_W-1:0] freq_khz;
   logic                        mode;

   modport source (output valid, output freq_khz, output mode, input ready);
   modport sink   (input valid, input freq_khz, input mode, output ready);
endinterface

// File: hw/rtl/tpwg_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner byte channel
// Valid/ready channel carrying four tuner bytes, a status and a last flag.
// ----------------------------------------------------------------------------
interface tpwg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tpwg_pkg::BYTE_W-1:0] byte0;
   logic [tpwg_pkg::BYTE_W-1:0] byte1;
   logic [tpwg_pkg::BYTE_W-1:0] byte2;
   logic [tpwg_pkg::BYTE_W-1:0] byte3;
   logic [1:0]                  status;
   logic                        last;

   modport source (output valid, output byte0, output byte1, output byte2,
                   output byte3, output status, output last, input ready);
   modport sink   (input valid, input byte0, input byte1, input byte2,
                   input byte3, input status, input last, output ready);
endinterface

// File: hw/rtl/tpwg_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator register file
// Write-only configuration registers, unpacked into one struct.
// ----------------------------------------------------------------------------
module tpwg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tpwg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tpwg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output tpwg_pkg::cfg_type                   cfg
);

   tpwg_pkg::cfg_type cfg_ff;
   tpwg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (tpwg_pkg::reg_index_type'(csr_index))
            tpwg_pkg::REG_TV_IF_KHZ:
               cfg_in.tv_if_khz = csr_wdata[tpwg_pkg::IF_W-1:0];
            tpwg_pkg::REG_TV_MIN_KHZ:
               cfg_in.tv_min_khz = csr_wdata[tpwg_pkg::FREQ_W-1:0];
            tpwg_pkg::REG_TV_MAX_KHZ:
               cfg_in.tv_max_khz = csr_wdata[tpwg_pkg::FREQ_W-1:0];
            tpwg_pkg::REG_BAND_HIGH_KHZ:
               cfg_in.band_high_khz = csr_wdata[tpwg_pkg::FREQ_W-1:0];
            tpwg_pkg::REG_BAND_MID_KHZ:
               cfg_in.band_mid_khz = csr_wdata[tpwg_pkg::FREQ_W-1:0];
            tpwg_pkg::REG_BAND_WORDS:
               cfg_in.band_words = csr_wdata[tpwg_pkg::WORDS_W-1:0];
            tpwg_pkg::REG_FM_SETTINGS: begin
               cfg_in.fm_min_khz = csr_wdata[57:37];
               cfg_in.fm_max_khz = csr_wdata[36:16];
               cfg_in.fm_word    = csr_wdata[15:0];
            end
            tpwg_pkg::REG_PORT_BITS:
               cfg_in.port_bits = csr_wdata[tpwg_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tv_if_khz     <= tpwg_pkg::RST_TV_IF_KHZ;
         cfg_ff.tv_min_khz    <= tpwg_pkg::RST_TV_MIN_KHZ;
         cfg_ff.tv_max_khz    <= tpwg_pkg::RST_TV_MAX_KHZ;
         cfg_ff.band_high_khz <= tpwg_pkg::RST_BAND_HIGH_KHZ;
         cfg_ff.band_mid_khz  <= tpwg_pkg::RST_BAND_MID_KHZ;
         cfg_ff.band_words    <= tpwg_pkg::RST_BAND_WORDS;
         cfg_ff.fm_min_khz    <= '0;
         cfg_ff.fm_max_khz    <= '0;
         cfg_ff.fm_word       <= '0;
         cfg_ff.port_bits     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/tpwg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator front end
// Accepts requests, runs the range checks and queues tune operations.
// ----------------------------------------------------------------------------
module tpwg_front (
   input  logic                clock,
   input  logic                reset,
   input  tpwg_pkg::cfg_type   cfg,
   tpwg_req_if.sink            req,
   output logic                q_valid,
   input  logic                q_ready,
   output tpwg_pkg::op_type    q_op
);

   logic                              pend_ff;
   logic                              pend_in;
   tpwg_pkg::op_type                  pend_op_ff;
   tpwg_pkg::op_type                  pend_op_in;
   tpwg_pkg::op_type                  new_op;
   tpwg_pkg::op_type                  fm_op;
   logic                              start_pend;
   logic                              accept;
   logic [tpwg_pkg::SUM_W-1:0]        tv_sum;
   logic [tpwg_pkg::SUM_W-1:0]        pre_sum;
   logic [tpwg_pkg::SUM_W-1:0]        fm_sum;
   logic [tpwg_pkg::DIVIDEND_W-1:0]   fm_div;
   logic                              tv_in_range;
   logic                              pre_in_range;
   logic                              fm_in_range;

   always_comb begin
      tv_sum  = {1'b0, req.freq_khz} + tpwg_pkg::SUM_W'(cfg.tv_if_khz);
      pre_sum = {1'b0, tpwg_pkg::FM_PRETUNE_KHZ} + tpwg_pkg::SUM_W'(cfg.tv_if_khz);
      fm_sum  = {1'b0, req.freq_khz} + tpwg_pkg::SUM_W'(tpwg_pkg::FM_IF_KHZ);
      fm_div  = tpwg_pkg::DIVIDEND_W'(fm_sum) * tpwg_pkg::DIVIDEND_W'(tpwg_pkg::FM_SCALE);

      tv_in_range  = (req.freq_khz >= cfg.tv_min_khz) && (req.freq_khz <= cfg.tv_max_khz);
      pre_in_range = (tpwg_pkg::FM_PRETUNE_KHZ >= cfg.tv_min_khz) &&
                     (tpwg_pkg::FM_PRETUNE_KHZ <= cfg.tv_max_khz);
      fm_in_range  = (req.freq_khz >= cfg.fm_min_khz) && (req.freq_khz <= cfg.fm_max_khz);

      fm_op.kind     = tpwg_pkg::OP_FM;
      fm_op.status   = tpwg_pkg::ST_OK;
      fm_op.last     = 1'b1;
      fm_op.chain    = 1'b0;
      fm_op.freq     = req.freq_khz;
      fm_op.dividend = fm_div;

      new_op.kind     = tpwg_pkg::OP_ERR;
      new_op.status   = tpwg_pkg::ST_RANGE;
      new_op.last     = 1'b1;
      new_op.chain    = 1'b0;
      new_op.freq     = req.freq_khz;
      new_op.dividend = {tv_sum, {tpwg_pkg::TV_SHIFT{1'b0}}};
      start_pend      = 1'b0;

      if (!req.mode) begin
         if (tv_in_range) begin
            new_op.kind   = tpwg_pkg::OP_TV;
            new_op.status = tpwg_pkg::ST_OK;
         end
      end else if (cfg.fm_min_khz == '0) begin
         new_op.status = tpwg_pkg::ST_FM_OFF;
      end else if (fm_in_range && pre_in_range) begin
         // pretune at the fixed TV frequency, FM word queued next
         new_op.kind     = tpwg_pkg::OP_TV;
         new_op.status   = tpwg_pkg::ST_OK;
         new_op.last     = 1'b0;
         new_op.chain    = 1'b1;
         new_op.freq     = tpwg_pkg::FM_PRETUNE_KHZ;
         new_op.dividend = {pre_sum, {tpwg_pkg::TV_SHIFT{1'b0}}};
         start_pend      = 1'b1;
      end
   end

   assign req.ready = !reset && !pend_ff && q_ready;
   assign accept    = req.valid && req.ready;
   assign q_valid   = pend_ff || req.valid;
   assign q_op      = pend_ff ? pend_op_ff : new_op;

   always_comb begin
      pend_in    = pend_ff;
      pend_op_in = pend_op_ff;
      if (pend_ff && q_ready) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         pend_in    = start_pend;
         pend_op_in = fm_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      pend_op_ff <= pend_op_in;
   end

endmodule

// File: hw/rtl/tpwg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator operation queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module tpwg_queue #(
   parameter int DEPTH = tpwg_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tpwg_pkg::op_type    push_op,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tpwg_pkg::op_type    pop_op
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tpwg_pkg::op_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: hw/rtl/tpwg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator back end
// Divides by 1000, checks the divider, picks the band and orders the bytes.
// ----------------------------------------------------------------------------
module tpwg_back (
   input  logic                clock,
   input  logic                reset,
   input  tpwg_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tpwg_pkg::op_type    pop_op,
   tpwg_rsp_if.source          rsp
);

   logic                              a_valid_ff;
   logic                              a_valid_in;
   tpwg_pkg::op_type                  a_op_ff;
   logic [tpwg_pkg::PROD_W-1:0]       a_prod_ff;
   logic [tpwg_pkg::PROD_W-1:0]       prod;
   logic                              a_move;
   logic                              a_free;
   logic                              a_load;

   logic [tpwg_pkg::DIVIDER_W-1:0]    n;
   logic                              ovf;
   logic [tpwg_pkg::WORD_W-1:0]       band_word;
   logic [tpwg_pkg::BYTE_W-1:0]       b0;
   logic [tpwg_pkg::BYTE_W-1:0]       b1;
   logic [tpwg_pkg::BYTE_W-1:0]       b2;
   logic [tpwg_pkg::BYTE_W-1:0]       b3;
   tpwg_pkg::status_type              st;
   logic                              lst;
   logic                              drop;
   logic                              upd;

   logic                              skip_ff;
   logic                              skip_in;
   logic [tpwg_pkg::FREQ_W-1:0]       last_tuned_ff;
   logic [tpwg_pkg::FREQ_W-1:0]       last_tuned_in;

   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [tpwg_pkg::BYTE_W-1:0]       out_b0_ff;
   logic [tpwg_pkg::BYTE_W-1:0]       out_b1_ff;
   logic [tpwg_pkg::BYTE_W-1:0]       out_b2_ff;
   logic [tpwg_pkg::BYTE_W-1:0]       out_b3_ff;
   tpwg_pkg::status_type              out_status_ff;
   logic                              out_last_ff;

   assign a_move    = a_valid_ff && (!out_valid_ff || rsp.ready);
   assign a_free    = !a_valid_ff || a_move;
   assign pop_ready = a_free;
   assign a_load    = a_free && pop_valid;
   assign a_valid_in = a_free ? pop_valid : a_valid_ff;
   assign prod = tpwg_pkg::PROD_W'(pop_op.dividend) * tpwg_pkg::PROD_W'(tpwg_pkg::RECIP_1000);

   always_comb begin
      n   = a_prod_ff[tpwg_pkg::PROD_W-1:tpwg_pkg::RECIP_SHIFT];
      ovf = (n > tpwg_pkg::DIV_MAX);

      if (a_op_ff.freq >= cfg.band_high_khz) begin
         band_word = cfg.band_words[47:32];
      end else if (a_op_ff.freq >= cfg.band_mid_khz) begin
         band_word = cfg.band_words[31:16];
      end else begin
         band_word = cfg.band_words[15:0];
      end

      b0      = '0;
      b1      = '0;
      b2      = '0;
      b3      = '0;
      st      = a_op_ff.status;
      lst     = 1'b1;
      drop    = 1'b0;
      upd     = 1'b0;
      skip_in = skip_ff;

      unique case (a_op_ff.kind)
         tpwg_pkg::OP_TV: begin
            if (ovf) begin
               st = tpwg_pkg::ST_OVF;
               if (a_op_ff.chain) begin
                  skip_in = 1'b1;
               end
            end else begin
               st  = tpwg_pkg::ST_OK;
               lst = a_op_ff.last;
               upd = 1'b1;
               if (a_op_ff.freq >= last_tuned_ff) begin
                  b0 = n[15:8];
                  b1 = n[7:0];
                  b2 = band_word[15:8];
                  b3 = band_word[7:0] | cfg.port_bits;
               end else begin
                  b0 = band_word[15:8];
                  b1 = band_word[7:0] | cfg.port_bits;
                  b2 = n[15:8];
                  b3 = n[7:0];
               end
            end
         end
         tpwg_pkg::OP_FM: begin
            if (skip_ff) begin
               drop    = 1'b1;
               skip_in = 1'b0;
            end else if (ovf) begin
               st = tpwg_pkg::ST_OVF;
            end else begin
               st  = tpwg_pkg::ST_OK;
               upd = 1'b1;
               b0  = n[15:8];
               b1  = n[7:0];
               b2  = cfg.fm_word[15:8];
               b3  = cfg.fm_word[7:0] | cfg.port_bits;
            end
         end
         default: ;
      endcase

      last_tuned_in = (a_move && upd) ? a_op_ff.freq : last_tuned_ff;

      if (a_move && !drop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skip_ff       <= 1'b0;
         last_tuned_ff <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         out_valid_ff  <= out_valid_in;
         last_tuned_ff <= last_tuned_in;
         if (a_move) begin
            skip_ff <= skip_in;
         end
      end
      if (a_load) begin
         a_op_ff   <= pop_op;
         a_prod_ff <= prod;
      end
      if (a_move && !drop) begin
         out_b0_ff     <= b0;
         out_b1_ff     <= b1;
         out_b2_ff     <= b2;
         out_b3_ff     <= b3;
         out_status_ff <= st;
         out_last_ff   <= lst;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.byte0  = out_b0_ff;
   assign rsp.byte1  = out_b1_ff;
   assign rsp.byte2  = out_b2_ff;
   assign rsp.byte3  = out_b3_ff;
   assign rsp.status = out_status_ff;
   assign rsp.last   = out_last_ff;

endmodule

// File: hw/rtl/tuner_pll_word_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator
// Turns tuning requests into the four programming bytes of a PLL tuner.
// ----------------------------------------------------------------------------
// A TV request yields one transaction. A pretuned FM request holds the request
// port until the front end has written the pretune and the FM word into the
// operation queue, one per cycle while the queue has room; an FM request
// yields one or two transactions. Results pass through the queue, the divide
// stage and the output register and can be taken when the result port is
// free. The queue of QUEUE_DEPTH operations lets requests keep coming while
// results wait.
// Write configuration only while idle.
module tuner_pll_word_generator_top #(
   parameter int QUEUE_DEPTH = tpwg_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tpwg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tpwg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   tpwg_req_if.sink                          req_ch,
   tpwg_rsp_if.source                        rsp_ch
);

`include "tuner_pll_word_generator_top_defines.svh"

   tpwg_pkg::cfg_type   cfg;
   logic                push_valid;
   logic                push_ready;
   tpwg_pkg::op_type    push_op;
   logic                pop_valid;
   logic                pop_ready;
   tpwg_pkg::op_type    pop_op;

   tpwg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpwg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_ch),
      .q_valid (push_valid),
      .q_ready (push_ready),
      .q_op    (push_op)
   );

   tpwg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   tpwg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .rsp       (rsp_ch)
   );

   `TPWG_ASSERT_SAME(a_err_zero, clock, reset, rsp_ch.valid && (rsp_ch.status != tpwg_pkg::ST_OK), (rsp_ch.byte0 == '0) && (rsp_ch.byte1 == '0) && (rsp_ch.byte2 == '0) && (rsp_ch.byte3 == '0) && rsp_ch.last, "error transaction carries bytes or is not last")
   `TPWG_ASSERT_SAME(a_notlast_ok, clock, reset, rsp_ch.valid && !rsp_ch.last, rsp_ch.status == tpwg_pkg::ST_OK, "non-final transaction with error status")
   `TPWG_ASSERT_NEXT(a_pretune_follow, clock, reset, push_valid && push_ready && push_op.chain, push_valid && (push_op.kind == tpwg_pkg::OP_FM) && !req_ch.ready, "pretune not followed by FM operation")

endmodule

// File: dv/tuner_pll_word_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner PLL word generator testbench
// Drives tuning requests through the request channel and checks every tuner
// word against a directed table or an in-bench model of the divider, band
// and FM pretune logic. The table covers reset values, range and threshold
// corners, every status code and the FM pretune paths. Randomized phases then
// sweep several register settings and idle/stall profiles on both channels.
// ----------------------------------------------------------------------------
module tuner_pll_word_generator_top_tb;
   import tpwg_pkg::*;

   localparam logic        MODE_TV          = 1'b0;
   localparam logic        MODE_FM          = 1'b1;
   localparam logic [20:0] PRETUNE_FREQ_KHZ = 21'd150000;
   localparam logic [31:0] FM_OFFSET_KHZ    = 32'd10700;
   localparam logic [31:0] DIVIDER_LIMIT    = 32'd32767;
   localparam logic [20:0] FREQ_TOP         = 21'h1FFFFF;

   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int          PHASE_COUNT     = 8;
   localparam int          ITEMS_PER_PHASE = 206;
   localparam int          PLAN_ROWS       = 35;

   typedef enum logic { ROW_TUNE, ROW_WRITE } row_kind_type;

   typedef enum logic [1:0] {
      SET_NOMINAL,
      SET_RANDOM,
      SET_MAX,
      SET_ZERO
   } setting_kind_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      status_type status;
      logic       last;
   } tuner_word_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type index;
      logic [57:0]   value;
      logic          mode;
      logic          pinned;
      logic [31:0]   exp_bytes;
      status_type    exp_status;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd55250,   MODE_TV, 1'b1, 32'h0650_8EA0, ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd801250,  MODE_TV, 1'b1, 32'h34F0_8E30, ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd160000,  MODE_TV, 1'b1, 32'h8E90_0CDC, ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd454000,  MODE_TV, 1'b1, 32'h1F3C_8E30, ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd55249,   MODE_TV, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd801251,  MODE_TV, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd0,       MODE_TV, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd2097151, MODE_TV, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd100000,  MODE_FM, 1'b1, 32'h0,         ST_FM_OFF},
      '{ROW_WRITE, REG_TV_IF_KHZ,     58'd65535,   MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_TV_MAX_KHZ,    58'd2097151, MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_TV_MIN_KHZ,    58'd0,       MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_PORT_BITS,     58'hFF,      MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd2097151, MODE_TV, 1'b1, 32'h0,         ST_OVF},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd0,       MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_FM_SETTINGS,   {21'd87500, 21'd108000, 16'h8EA4},
                                                   MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd87500,   MODE_FM, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd108000,  MODE_FM, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd87499,   MODE_FM, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd108001,  MODE_FM, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_WRITE, REG_FM_SETTINGS,   {21'd1, 21'h1FFFFF, 16'hFFFF},
                                                   MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd2097151, MODE_FM, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd1,       MODE_FM, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_TV_MIN_KHZ,    58'd150001,  MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd100000,  MODE_FM, 1'b1, 32'h0,         ST_RANGE},
      '{ROW_WRITE, REG_TV_MIN_KHZ,    58'd0,       MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_BAND_HIGH_KHZ, 58'd100000,  MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_BAND_MID_KHZ,  58'd500000,  MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd99999,   MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd300000,  MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd600000,  MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_BAND_WORDS,    58'h0123_4567_89AB,
                                                   MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_WRITE, REG_PORT_BITS,     58'd0,       MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd500000,  MODE_TV, 1'b0, 32'h0,         ST_OK},
      '{ROW_TUNE,  REG_TV_IF_KHZ,     58'd250000,  MODE_TV, 1'b0, 32'h0,         ST_OK}
   };

   localparam setting_kind_type PHASE_SETTING [PHASE_COUNT] = '{
      SET_NOMINAL, SET_MAX, SET_RANDOM, SET_ZERO,
      SET_RANDOM, SET_NOMINAL, SET_RANDOM, SET_RANDOM
   };
   localparam int unsigned SENDER_IDLE_PCT [4] = '{0, 60, 0, 32};
   localparam int unsigned RSP_STALL_PCT   [4] = '{0, 0, 60, 32};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tpwg_req_if req_ch ();
   tpwg_rsp_if rsp_ch ();

   cfg_type        tuner_cfg;
   logic [20:0]    last_tuned_khz;
   tuner_word_type expected_words [$];
   logic           hold_pinned;
   tuner_word_type held_word;
   int unsigned    sender_idle_pct;
   int unsigned    rsp_stall_pct;
   int unsigned    mismatch_count;
   int unsigned    quiet_cycles;

   tuner_pll_word_generator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic status_type tune_tv(input logic [20:0] f, output logic [31:0] tv_bytes);
      logic [31:0] n;
      logic [15:0] word;
      logic [7:0]  band;
      tv_bytes = '0;
      if (f < tuner_cfg.tv_min_khz || f > tuner_cfg.tv_max_khz) return ST_RANGE;
      n = (32'd16 * ({11'd0, f} + {16'd0, tuner_cfg.tv_if_khz})) / 32'd1000;
      if (n > DIVIDER_LIMIT) return ST_OVF;
      if (f >= tuner_cfg.band_high_khz) begin
         word = tuner_cfg.band_words[47:32];
      end else if (f >= tuner_cfg.band_mid_khz) begin
         word = tuner_cfg.band_words[31:16];
      end else begin
         word = tuner_cfg.band_words[15:0];
      end
      band = word[7:0] | tuner_cfg.port_bits;
      if (f >= last_tuned_khz) begin
         tv_bytes = {n[15:0], word[15:8], band};
      end else begin
         tv_bytes = {word[15:8], band, n[15:0]};
      end
      last_tuned_khz = f;
      return ST_OK;
   endfunction

   function automatic int predict_request(input logic [20:0] f, input logic mode,
                                          output tuner_word_type words [2]);
      logic [31:0] tv_bytes;
      logic [31:0] n;
      status_type  st;
      words[0] = '0;
      words[1] = '0;
      if (mode == MODE_TV) begin
         st = tune_tv(f, tv_bytes);
         words[0] = {tv_bytes, st, 1'b1};
         return 1;
      end
      if (tuner_cfg.fm_min_khz == '0) begin
         words[0] = {32'h0, ST_FM_OFF, 1'b1};
         return 1;
      end
      if (f < tuner_cfg.fm_min_khz || f > tuner_cfg.fm_max_khz) begin
         words[0] = {32'h0, ST_RANGE, 1'b1};
         return 1;
      end
      st = tune_tv(PRETUNE_FREQ_KHZ, tv_bytes);
      if (st != ST_OK) begin
         words[0] = {tv_bytes, st, 1'b1};
         return 1;
      end
      words[0] = {tv_bytes, ST_OK, 1'b0};
      n = (32'd20 * ({11'd0, f} + FM_OFFSET_KHZ)) / 32'd1000;
      if (n > DIVIDER_LIMIT) begin
         words[1] = {32'h0, ST_OVF, 1'b1};
         return 2;
      end
      words[1] = {n[15:0], tuner_cfg.fm_word[15:8],
                  tuner_cfg.fm_word[7:0] | tuner_cfg.port_bits, ST_OK, 1'b1};
      last_tuned_khz = f;
      return 2;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
   endfunction

   task automatic drive_tuning(input logic [20:0] f, input logic mode, input logic pinned,
                               input tuner_word_type pinned_word);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      hold_pinned = pinned;
      held_word = pinned_word;
      req_ch.valid <= 1'b1;
      req_ch.freq_khz <= f;
      req_ch.mode <= mode;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [57:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TV_IF_KHZ:     tuner_cfg.tv_if_khz = data[15:0];
         REG_TV_MIN_KHZ:    tuner_cfg.tv_min_khz = data[20:0];
         REG_TV_MAX_KHZ:    tuner_cfg.tv_max_khz = data[20:0];
         REG_BAND_HIGH_KHZ: tuner_cfg.band_high_khz = data[20:0];
         REG_BAND_MID_KHZ:  tuner_cfg.band_mid_khz = data[20:0];
         REG_BAND_WORDS:    tuner_cfg.band_words = data[47:0];
         REG_FM_SETTINGS: begin
            tuner_cfg.fm_min_khz = data[57:37];
            tuner_cfg.fm_max_khz = data[36:16];
            tuner_cfg.fm_word = data[15:0];
         end
         REG_PORT_BITS:     tuner_cfg.port_bits = data[7:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : check_proc
      tuner_word_type predicted [2];
      tuner_word_type seen;
      tuner_word_type want;
      int             count;
      logic           moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            count = predict_request(req_ch.freq_khz, req_ch.mode, predicted);
            if (hold_pinned) begin
               expected_words.push_back(held_word);
            end else begin
               for (int i = 0; i < count; i++) expected_words.push_back(predicted[i]);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            seen = {rsp_ch.byte0, rsp_ch.byte1, rsp_ch.byte2, rsp_ch.byte3,
                    rsp_ch.status, rsp_ch.last};
            if (expected_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected tuner word: expected none, got %h", $time, seen);
            end else begin
               want = expected_words.pop_front();
               check_field("byte0", want.byte0, seen.byte0);
               check_field("byte1", want.byte1, seen.byte1);
               check_field("byte2", want.byte2, seen.byte2);
               check_field("byte3", want.byte3, seen.byte3);
               check_field("status", {6'd0, want.status}, {6'd0, seen.status});
               check_field("last", {7'd0, want.last}, {7'd0, seen.last});
            end
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      plan_row_type row;
      logic [57:0]  vals [8];
      logic [63:0]  junk;
      logic [20:0]  tv_lo;
      logic [20:0]  tv_hi;
      logic [20:0]  fm_lo;
      logic [20:0]  fm_hi;
      logic [20:0]  lo;
      logic [20:0]  hi;
      logic [20:0]  f;
      logic [20:0]  corners [9];
      logic         mode;
      int unsigned  pick;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_TV_IF_KHZ;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.freq_khz = '0;
      req_ch.mode = MODE_TV;
      rsp_ch.ready = 1'b0;
      hold_pinned = 1'b0;
      held_word = '0;
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      mismatch_count = 0;
      quiet_cycles = 0;

      tuner_cfg.tv_if_khz = 16'd45750;
      tuner_cfg.tv_min_khz = 21'd55250;
      tuner_cfg.tv_max_khz = 21'd801250;
      tuner_cfg.band_high_khz = 21'd454000;
      tuner_cfg.band_mid_khz = 21'd160000;
      tuner_cfg.band_words = 48'h8E30_8E90_8EA0;
      tuner_cfg.fm_min_khz = '0;
      tuner_cfg.fm_max_khz = '0;
      tuner_cfg.fm_word = '0;
      tuner_cfg.port_bits = '0;
      last_tuned_khz = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_WRITE) begin
            drain_results();
            write_register(row.index, row.value);
         end else begin
            drive_tuning(row.value[20:0], row.mode, row.pinned,
                         {row.exp_bytes, row.exp_status, 1'b1});
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         case (PHASE_SETTING[phase])
            SET_NOMINAL: begin
               vals[REG_TV_IF_KHZ] = 58'd45750;
               vals[REG_TV_MIN_KHZ] = 58'd55250;
               vals[REG_TV_MAX_KHZ] = 58'd801250;
               vals[REG_BAND_HIGH_KHZ] = 58'd454000;
               vals[REG_BAND_MID_KHZ] = 58'd160000;
               vals[REG_BAND_WORDS] = 58'h8E30_8E90_8EA0;
               vals[REG_FM_SETTINGS] = {21'd87500, 21'd108000, 16'($urandom)};
               vals[REG_PORT_BITS] = {50'd0, 8'($urandom)};
            end
            SET_MAX: begin
               for (int i = 0; i < 8; i++) vals[i] = '1;
               vals[REG_TV_MIN_KHZ] = '0;
               vals[REG_BAND_MID_KHZ] = '0;
            end
            SET_ZERO: begin
               for (int i = 0; i < 8; i++) vals[i] = '0;
            end
            default: begin
               for (int i = 0; i < 8; i++) begin
                  junk = {$urandom, $urandom};
                  vals[i] = junk[57:0];
               end
               tv_lo = 21'($urandom_range(150000));
               tv_hi = 21'($urandom_range(32'(FREQ_TOP), 150000));
               vals[REG_TV_MIN_KHZ][20:0] = tv_lo;
               vals[REG_TV_MAX_KHZ][20:0] = tv_hi;
               vals[REG_BAND_HIGH_KHZ][20:0] = 21'($urandom_range(32'(tv_hi), 32'(tv_lo)));
               vals[REG_BAND_MID_KHZ][20:0] = 21'($urandom_range(32'(tv_hi), 32'(tv_lo)));
               fm_lo = ($urandom_range(7) == 0) ? 21'd0 : 21'($urandom_range(1200000, 1));
               fm_hi = 21'($urandom_range(32'(FREQ_TOP), 32'(fm_lo)));
               vals[REG_FM_SETTINGS][57:16] = {fm_lo, fm_hi};
            end
         endcase
         for (int i = 0; i < 8; i++) write_register(reg_index_type'(i), vals[i]);
         sender_idle_pct = SENDER_IDLE_PCT[phase / 2];
         rsp_stall_pct = RSP_STALL_PCT[phase / 2];

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // hold the sender until every outstanding word is back
            if (phase == 3 && k == ITEMS_PER_PHASE / 2) drain_results();
            if (tuner_cfg.fm_min_khz != '0) begin
               mode = ($urandom_range(99) < 50) ? MODE_FM : MODE_TV;
            end else begin
               mode = ($urandom_range(99) < 20) ? MODE_FM : MODE_TV;
            end
            if (mode == MODE_FM && tuner_cfg.fm_min_khz != '0) begin
               lo = tuner_cfg.fm_min_khz;
               hi = tuner_cfg.fm_max_khz;
            end else begin
               lo = tuner_cfg.tv_min_khz;
               hi = tuner_cfg.tv_max_khz;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
               f = 21'($urandom_range(32'(hi), 32'(lo)));
            end else if (pick < 85) begin
               corners = '{lo, hi, lo - 21'd1, hi + 21'd1, tuner_cfg.band_high_khz,
                           tuner_cfg.band_mid_khz, tuner_cfg.band_high_khz - 21'd1,
                           PRETUNE_FREQ_KHZ, last_tuned_khz};
               f = corners[$urandom_range(8)];
            end else begin
               f = 21'($urandom);
            end
            drive_tuning(f, mode, 1'b0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
